@@ rtl/mlb_pkg.sv @@
// package for the morse letter led blinker
// letter tables, register indexes and shared types; no dependencies
package mlb_pkg;

	localparam int unsigned TickW     = 16;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned LetterCnt = 8;
	localparam int unsigned LetterW   = $clog2(LetterCnt);
	localparam int unsigned PosW      = 2;
	localparam int unsigned LenW      = 3;

	// register indexes on the config port
	localparam logic [CfgIdxW-1:0] CfgDotTicks       = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgDashTicks      = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgSymbolGapTicks = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgLetterGapTicks = 3'd3;

	localparam logic [TickW-1:0] DotTicksRst       = 16'd150;
	localparam logic [TickW-1:0] DashTicksRst      = 16'd500;
	localparam logic [TickW-1:0] SymbolGapTicksRst = 16'd150;
	localparam logic [TickW-1:0] LetterGapTicksRst = 16'd1000;

	// supported letters in table order: D P R E I L A N
	localparam logic [6:0] LetterAscii [LetterCnt] = '{
		7'h44, 7'h50, 7'h52, 7'h45, 7'h49, 7'h4C, 7'h41, 7'h4E
	};
	localparam logic [LenW-1:0] LetterLen [LetterCnt] = '{
		3'd3, 3'd4, 3'd3, 3'd1, 3'd2, 3'd4, 3'd2, 3'd2
	};
	// bit i set: symbol i is a dash
	localparam logic [3:0] LetterDash [LetterCnt] = '{
		4'h1, 4'h6, 4'h2, 4'h0, 4'h0, 4'h2, 4'h2, 4'h1
	};

	typedef struct packed {
		logic               hit;
		logic [LetterW-1:0] idx;
	} letter_match_t;

	typedef struct packed {
		logic               running;
		logic               lit;
		logic [PosW-1:0]    pos;
		logic [TickW-1:0]   wait_left;
		logic [LetterW-1:0] letter;
	} seq_state_t;

	// upper-case a..z, then look the code up among the supported letters
	function automatic letter_match_t find_letter(input logic [7:0] code);
		logic [7:0]    c;
		letter_match_t m;
		c = code;
		m = '0;
		if (code >= 8'h61 && code <= 8'h7A) begin
			c = code - 8'd32;
		end
		for (int i = LetterCnt - 1; i >= 0; i--) begin
			if (c == {1'b0, LetterAscii[i]}) begin
				m.hit = 1'b1;
				m.idx = LetterW'(i);
			end
		end
		return m;
	endfunction

	function automatic logic at_last_symbol(input logic [LetterW-1:0] idx,
			input logic [PosW-1:0] pos);
		return ({1'b0, pos} + 3'd1) >= LetterLen[idx];
	endfunction

endpackage

@@ rtl/morse_letter_led_blinker.sv @@
// morse letter led blinker top level
// depends on mlb_pkg
//
// one item enters on the in channel (opcode, char_code) per transfer: opcode 0 is a
// millisecond tick, opcode 1 selects a letter among D P R E I L A N (lower case
// accepted). every item gives exactly one result on the out channel: led_on,
// select_ok and shown_char after that item.
// an item is taken into the input register; as it moves on, the sequence state
// is updated and the result register is loaded, so a result passes through the
// input register and then the result register. while out_stall is low, one item
// per cycle is sustained; the single state update per cycle sets that figure.
// in_stall rises only when both the input register and the result register
// hold items and out_stall is high; a stalled result holds its value.
// reset clears both stages and the sequence (led dark, letter D, next tick
// lights the first symbol) and loads the default durations 150/500/150/1000.
// the config port writes one duration register per cycle when cfg_we is high;
// indexes past the fourth register are ignored. write only while idle.
module morse_letter_led_blinker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [7:0]                  char_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        led_on,
	output logic                        select_ok,
	output logic [6:0]                  shown_char,
	input  logic                        cfg_we,
	input  logic [mlb_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [mlb_pkg::TickW-1:0]   cfg_data
);

	logic                      valid_s1;
	logic                      opcode_s1;
	logic [7:0]                char_code_s1;
	logic                      valid_s2;
	logic                      led_s2;
	logic                      ok_s2;
	logic [6:0]                char_s2;
	logic [mlb_pkg::TickW-1:0] dot_ticks_q;
	logic [mlb_pkg::TickW-1:0] dash_ticks_q;
	logic [mlb_pkg::TickW-1:0] symbol_gap_ticks_q;
	logic [mlb_pkg::TickW-1:0] letter_gap_ticks_q;
	mlb_pkg::seq_state_t       state_q;
	mlb_pkg::seq_state_t       state_nxt;
	mlb_pkg::letter_match_t    match;
	logic                      ok_nxt;
	logic                      move_s1;
	logic                      load_s1;
	logic [mlb_pkg::PosW-1:0]  pos_inc;

	assign move_s1  = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = !valid_s1 || move_s1;
	assign in_stall = !load_s1;

	assign match   = mlb_pkg::find_letter(char_code_s1);
	assign pos_inc = state_q.pos + 2'd1;

	always_comb begin
		state_nxt = state_q;
		ok_nxt    = 1'b0;
		if (opcode_s1) begin
			if (match.hit) begin
				ok_nxt           = 1'b1;
				state_nxt        = '0;
				state_nxt.letter = match.idx;
			end
		end else if (state_q.wait_left > 16'd1) begin
			state_nxt.wait_left = state_q.wait_left - 16'd1;
		end else if (!state_q.running) begin
			// start of the letter: light the first symbol
			state_nxt.running   = 1'b1;
			state_nxt.lit       = 1'b1;
			state_nxt.pos       = '0;
			state_nxt.wait_left = mlb_pkg::LetterDash[state_q.letter][0]
				? dash_ticks_q : dot_ticks_q;
		end else if (state_q.lit) begin
			state_nxt.lit       = 1'b0;
			state_nxt.wait_left = mlb_pkg::at_last_symbol(state_q.letter, state_q.pos)
				? letter_gap_ticks_q : symbol_gap_ticks_q;
		end else if (mlb_pkg::at_last_symbol(state_q.letter, state_q.pos)) begin
			// letter gap done, restart on next tick
			state_nxt.running   = 1'b0;
			state_nxt.pos       = '0;
			state_nxt.wait_left = '0;
		end else begin
			state_nxt.pos       = pos_inc;
			state_nxt.lit       = 1'b1;
			state_nxt.wait_left = mlb_pkg::LetterDash[state_q.letter][pos_inc]
				? dash_ticks_q : dot_ticks_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			opcode_s1    <= opcode;
			char_code_s1 <= char_code;
		end
		if (move_s1) begin
			led_s2  <= state_nxt.lit;
			ok_s2   <= ok_nxt;
			char_s2 <= mlb_pkg::LetterAscii[state_nxt.letter];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_ticks_q        <= mlb_pkg::DotTicksRst;
			dash_ticks_q       <= mlb_pkg::DashTicksRst;
			symbol_gap_ticks_q <= mlb_pkg::SymbolGapTicksRst;
			letter_gap_ticks_q <= mlb_pkg::LetterGapTicksRst;
		end else if (cfg_we) begin
			case (cfg_index)
				mlb_pkg::CfgDotTicks:       dot_ticks_q        <= cfg_data;
				mlb_pkg::CfgDashTicks:      dash_ticks_q       <= cfg_data;
				mlb_pkg::CfgSymbolGapTicks: symbol_gap_ticks_q <= cfg_data;
				mlb_pkg::CfgLetterGapTicks: letter_gap_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid  = valid_s2;
	assign led_on     = led_s2;
	assign select_ok  = ok_s2;
	assign shown_char = char_s2;

endmodule

@@ rtl/mlb_checker.sv @@
// port-level checks for the morse letter led blinker
// depends on mlb_pkg; bound to the top level at the end of this file
module mlb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        led_on,
	input logic                        select_ok,
	input logic [6:0]                  shown_char
);

	// an empty result register never pushes back on the input
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// an accepted select always restarts the letter dark
	a_select_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && select_ok |-> !led_on)
		else $error("led lit on accepted select");

	a_shown_supported: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (shown_char == mlb_pkg::LetterAscii[0]
			|| shown_char == mlb_pkg::LetterAscii[1]
			|| shown_char == mlb_pkg::LetterAscii[2]
			|| shown_char == mlb_pkg::LetterAscii[3]
			|| shown_char == mlb_pkg::LetterAscii[4]
			|| shown_char == mlb_pkg::LetterAscii[5]
			|| shown_char == mlb_pkg::LetterAscii[6]
			|| shown_char == mlb_pkg::LetterAscii[7]))
		else $error("shown_char is not a supported letter");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_on)
			&& $stable(select_ok) && $stable(shown_char))
		else $error("stalled result changed");

endmodule

bind morse_letter_led_blinker mlb_checker u_mlb_checker (.*);
